// ===== sv/gbss_pkg.sv =====
`default_nettype none
package gbss_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 12;
	localparam int POS_W = 5;
	localparam int PAD_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
	localparam logic [SUM_W-1:0] SUM_MAX = 12'd4095;
	localparam logic [POS_W-1:0] POS_MAX = 5'd30 + 5'd1;

	localparam logic [CFG_IDX_W-1:0] REG_BOLD_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH = 1'd1;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic row_done;
		logic last;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/gbss_cell.sv =====
`default_nettype none
module gbss_cell #(
	parameter int IDX = 0,
	parameter int IW = 4
) (
	input wire logic clk,
	input wire logic shift,
	input wire logic [gbss_pkg::PIX_W-1:0] d,
	input wire logic [IW-1:0] tap_sel,
	output logic [gbss_pkg::PIX_W-1:0] q,
	output logic [gbss_pkg::PIX_W-1:0] tap_data
);

	logic [gbss_pkg::PIX_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;
	assign tap_data = (tap_sel == IW'(IDX)) ? data_q : '0;

endmodule
`default_nettype wire

// ===== sv/gbss_outq.sv =====
`default_nettype none
module gbss_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire gbss_pkg::res_t push_data,
	output logic space,
	output logic out_valid,
	input wire logic out_ready,
	output gbss_pkg::res_t out_data
);

	gbss_pkg::res_t mem [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign space = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("Output queue count out of range.");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2)) else $error("Output queue written while full.");

endmodule
`default_nettype wire

// ===== sv/glyph_bold_sliding_sum_top.sv =====
// Channel | Direction | Signals                          | Contents
// s       | in        | s_tvalid s_tready s_tdata s_tlast | pixel, row_end
// m       | out       | m_tvalid m_tready m_tdata m_tlast m_tuser | out_pixel, row_done, last
// cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data | register writes
// One pixel is accepted per cycle while the output queue has room.
// In bold mode a row-end pixel is followed by a flush of one zero pixel per pad
// position, in which no pixel is accepted; a row of w pixels gives w + pad results.
// A result leaves through a two-entry output queue; a stalled consumer halts the chain.
// Reset clears the window sum, the row position and the flush counter, and sets
// bold_enable and pad_width to 1; the history cells are not cleared.
`default_nettype none
module glyph_bold_sliding_sum_top #(
	parameter int MAX_PAD = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] pixel
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // [7:0] out_pixel
	output logic m_tlast,
	output logic [0:0] m_tuser, // [0] last
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [gbss_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [gbss_pkg::PAD_W-1:0] cfg_data
);

	localparam int EFF_PAD = (MAX_PAD < 15) ? MAX_PAD : 15;
	localparam int NCELL = EFF_PAD + 1;
	localparam int IW = (NCELL > 1) ? $clog2(NCELL) : 1;

	logic bold_q;
	logic [gbss_pkg::PAD_W-1:0] pad_q;
	logic [gbss_pkg::SUM_W-1:0] sum_q;
	logic [gbss_pkg::POS_W-1:0] pos_q;
	logic [gbss_pkg::PAD_W-1:0] flush_rem_q;

	logic [gbss_pkg::PAD_W-1:0] pad_act;
	logic flushing;
	logic space;
	logic take;
	logic step;
	logic bold_step;
	logic end_now;
	logic [gbss_pkg::PIX_W-1:0] pix_in;
	logic [gbss_pkg::PIX_W-1:0] tap;
	logic do_sub;
	logic [gbss_pkg::SUM_W:0] add_sum;
	logic [gbss_pkg::SUM_W:0] sub_sum;
	logic [gbss_pkg::SUM_W-1:0] sum_new;
	gbss_pkg::res_t res;
	gbss_pkg::res_t out_res;

	logic [gbss_pkg::PIX_W-1:0] chain [NCELL+1];
	logic [gbss_pkg::PIX_W-1:0] taps [NCELL];

	assign cfg_ready = 1'b1;
	assign pad_act = (pad_q > gbss_pkg::PAD_W'(EFF_PAD)) ? gbss_pkg::PAD_W'(EFF_PAD) : pad_q;
	assign flushing = (flush_rem_q != '0);
	assign s_tready = space && !flushing;
	assign take = s_tvalid && s_tready;
	assign step = flushing ? space : take;
	assign bold_step = step && (bold_q || flushing);
	assign pix_in = flushing ? '0 : s_tdata;
	assign end_now = flushing ? (flush_rem_q == gbss_pkg::PAD_W'(1))
		: (s_tlast && (pad_act == '0));

	assign chain[0] = pix_in;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		gbss_cell #(
			.IDX(i),
			.IW(IW)
		) u_cell (
			.clk(clk),
			.shift(bold_step),
			.d(chain[i]),
			.tap_sel(pad_act[IW-1:0]),
			.q(chain[i+1]),
			.tap_data(taps[i])
		);
	end

	always_comb begin
		tap = '0;
		for (int i = 0; i < NCELL; i++) begin
			tap = tap | taps[i];
		end
	end

	always_comb begin
		do_sub = (pos_q > gbss_pkg::POS_W'(pad_act));
		add_sum = {1'b0, sum_q} + {{(gbss_pkg::SUM_W + 1 - gbss_pkg::PIX_W){1'b0}}, pix_in};
		if (!do_sub) begin
			sub_sum = add_sum;
		end else if ({{(gbss_pkg::SUM_W + 1 - gbss_pkg::PIX_W){1'b0}}, tap} > add_sum) begin
			sub_sum = '0;
		end else begin
			sub_sum = add_sum - {{(gbss_pkg::SUM_W + 1 - gbss_pkg::PIX_W){1'b0}}, tap};
		end
		sum_new = sub_sum[gbss_pkg::SUM_W] ? gbss_pkg::SUM_MAX : sub_sum[gbss_pkg::SUM_W-1:0];
	end

	always_comb begin
		if (bold_q || flushing) begin
			res.out_pixel = (sum_new > {4'd0, gbss_pkg::PIX_MAX}) ? gbss_pkg::PIX_MAX
				: sum_new[gbss_pkg::PIX_W-1:0];
			res.row_done = end_now;
			res.last = end_now || (!flushing && !s_tlast);
		end else begin
			res.out_pixel = s_tdata;
			res.row_done = s_tlast;
			res.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bold_q <= 1'b1;
			pad_q <= gbss_pkg::PAD_W'(1);
			sum_q <= '0;
			pos_q <= '0;
			flush_rem_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					gbss_pkg::REG_BOLD_ENABLE: bold_q <= cfg_data[0];
					gbss_pkg::REG_PAD_WIDTH: pad_q <= cfg_data;
					default: ;
				endcase
			end
			if (bold_step) begin
				if (end_now) begin
					sum_q <= '0;
					pos_q <= '0;
				end else begin
					sum_q <= sum_new;
					if (pos_q != gbss_pkg::POS_MAX) begin
						pos_q <= pos_q + gbss_pkg::POS_W'(1);
					end
				end
				if (flushing) begin
					flush_rem_q <= flush_rem_q - gbss_pkg::PAD_W'(1);
				end else if (s_tlast) begin
					flush_rem_q <= pad_act;
				end
			end else if (step) begin
				sum_q <= '0;
				pos_q <= '0;
			end
		end
	end

	gbss_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(step),
		.push_data(res),
		.space(space),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_res)
	);

	assign m_tdata = out_res.out_pixel;
	assign m_tlast = out_res.row_done;
	assign m_tuser = out_res.last;

	a_no_take_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flushing |-> !s_tready) else $error("Pixel accepted during a row flush.");
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !res.last) |=> flushing) else $error("Missing flush after a row end.");
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(bold_step && end_now) |=> (sum_q == '0 && pos_q == '0 && !flushing))
		else $error("Row state not cleared after the row end.");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] px;
		logic row_end;
	} pixel_req_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic [0:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gbss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gbss_pkg::PAD_W-1:0] cfg_data = '0;

	pixel_req_t pixel_requests[$];
	pixel_req_t next_req;
	gbss_pkg::res_t expected_px[$];
	gbss_pkg::res_t want;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int failures = 0;

	logic bold_en;
	logic [gbss_pkg::PAD_W-1:0] pad_cfg;
	logic [7:0] hist[16];
	logic [gbss_pkg::SUM_W-1:0] win_sum;
	logic [gbss_pkg::POS_W-1:0] row_pos;

	glyph_bold_sliding_sum_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] clip_pixel(input int sum);
		return (sum > gbss_pkg::PIX_MAX) ? gbss_pkg::PIX_MAX : sum[7:0];
	endfunction

	function automatic int drop_pixel(input int sum, input logic [7:0] px);
		return (px > sum) ? 0 : sum - px;
	endfunction

	function automatic void smear_pixel(input logic [7:0] px, input logic row_end);
		int pad;
		int pos;
		int sum;
		gbss_pkg::res_t r;
		if (!bold_en) begin
			win_sum = '0;
			row_pos = '0;
			r = '{out_pixel: px, row_done: row_end, last: 1'b1};
			expected_px = {expected_px, r};
			return;
		end
		pad = (pad_cfg > 15) ? 15 : pad_cfg;
		sum = win_sum + px;
		if (row_pos > pad)
			sum = drop_pixel(sum, hist[pad]);
		if (sum > gbss_pkg::SUM_MAX)
			sum = gbss_pkg::SUM_MAX;
		for (int i = 15; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = px;
		pos = row_pos;
		if (row_pos < gbss_pkg::POS_MAX)
			row_pos = row_pos + 1'b1;
		if (!row_end) begin
			win_sum = gbss_pkg::SUM_W'(sum);
			r = '{out_pixel: clip_pixel(sum), row_done: 1'b0, last: 1'b1};
			expected_px = {expected_px, r};
			return;
		end
		r = '{out_pixel: clip_pixel(sum), row_done: pad == 0, last: pad == 0};
		expected_px = {expected_px, r};
		for (int t = 1; t <= pad; t++) begin
			if (pos + t > pad)
				sum = drop_pixel(sum, hist[pad + 1 - t]);
			r = '{out_pixel: clip_pixel(sum), row_done: t == pad, last: t == pad};
			expected_px = {expected_px, r};
		end
		win_sum = '0;
		row_pos = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pixel_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pixel_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_req.px;
				s_tlast <= next_req.row_end;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bold_en = 1'b1;
			pad_cfg = 4'd1;
			win_sum = '0;
			row_pos = '0;
			for (int i = 0; i < 16; i++)
				hist[i] = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gbss_pkg::REG_BOLD_ENABLE)
					bold_en = cfg_data[0];
				else if (cfg_index == gbss_pkg::REG_PAD_WIDTH)
					pad_cfg = cfg_data;
			end
			if (s_tvalid && s_tready)
				smear_pixel(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_px.size() == 0) begin
					failures++;
					$display("%0t: unexpected result out_pixel=%0d row_done=%0b last=%0b",
						$time, m_tdata, m_tlast, m_tuser[0]);
				end else begin
					want = expected_px.pop_front();
					if (m_tdata !== want.out_pixel || m_tlast !== want.row_done ||
							m_tuser[0] !== want.last) begin
						failures++;
						$display("%0t: mismatch expected %0d/%0b/%0b actual %0d/%0b/%0b",
							$time, want.out_pixel, want.row_done, want.last,
							m_tdata, m_tlast, m_tuser[0]);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [gbss_pkg::CFG_IDX_W-1:0] idx,
			input logic [gbss_pkg::PAD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input logic bold, input logic [gbss_pkg::PAD_W-1:0] pad);
		write_reg(gbss_pkg::REG_BOLD_ENABLE, {3'($urandom_range(7)), bold});
		write_reg(gbss_pkg::REG_PAD_WIDTH, pad);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (pixel_requests.size() != 0 || s_tvalid || expected_px.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_pixel(input logic [7:0] px, input logic row_end);
		pixel_req_t r;
		r.px = px;
		r.row_end = row_end;
		pixel_requests = {pixel_requests, r};
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 15));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic add_row(input int width);
		for (int i = 0; i < width; i++)
			add_pixel(pick_pixel(), i == width - 1);
	endtask

	initial begin
		int count;
		int width;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b1);
		add_pixel(8'd0, 1'b1);
		add_pixel(8'd128, 1'b0);
		add_pixel(8'd200, 1'b1);
		wait_drain();
		set_mode(1'b1, 4'd15);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd1, 1'b0);
		add_pixel(8'd2, 1'b1);
		wait_drain();
		set_mode(1'b1, 4'd0);
		add_pixel(8'd7, 1'b0);
		add_pixel(8'd255, 1'b1);
		wait_drain();
		write_reg(gbss_pkg::REG_PAD_WIDTH, 4'd3);
		add_pixel(8'd10, 1'b0);
		add_pixel(8'd20, 1'b0);
		add_pixel(8'd30, 1'b0);
		add_pixel(8'd40, 1'b0);
		wait_drain();
		write_reg(gbss_pkg::REG_PAD_WIDTH, 4'd1);
		add_pixel(8'd50, 1'b0);
		add_pixel(8'd60, 1'b1);
		wait_drain();
		set_mode(1'b0, 4'd15);
		add_pixel(8'd255, 1'b1);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd9, 1'b1);
		wait_drain();
		set_mode(1'b1, 4'd2);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b1);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 46; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int k = 0; k < 3; k++) begin
				if (k == 0)
					set_mode(1'b1, (p % 2) ? 4'd15 : 4'd0);
				else
					set_mode($urandom_range(4) != 0, 4'($urandom_range(15)));
				count = 0;
				while (count < 12) begin
					width = ($urandom_range(11) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 10);
					if (k == 2 && count == 0) begin
						for (int i = 0; i < 5; i++)
							add_pixel(pick_pixel(), 1'b0);
						wait_drain();
						write_reg(gbss_pkg::REG_PAD_WIDTH, 4'($urandom_range(15)));
						count += 5;
					end
					add_row(width);
					count += width;
				end
				wait_drain();
			end
		end

		if (failures == 0)
			$display("[glyph_bold_sliding_sum_top] OK");
		else
			$display("[glyph_bold_sliding_sum_top] ERROR");
		$finish;
	end

	initial begin
		#200us;
		$display("[glyph_bold_sliding_sum_top] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/gbss_pkg.sv
sv/gbss_cell.sv
sv/gbss_outq.sv
sv/glyph_bold_sliding_sum_top.sv
tb/tb.sv
